/* rtl/btd_pkg.sv */
package btd_pkg;

  // One input transfer: a raw byte of token text and its end-of-token flag.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       token_end;
  } in_item_t;

  // One result transfer.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       token_done;
  } out_item_t;

  // One finished code point, ready to be emitted as a run of one to four bytes.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            tok_end;
  } run_t;

  localparam int unsigned RUN_Q_DEPTH = 4;
  localparam int unsigned RUN_Q_AW    = 2;
  localparam int unsigned CP_W        = 21;

  // Inverse of the byte-to-unicode table. Bit 8 is set when the code point maps.
  function automatic logic [8:0] map_code(input logic [CP_W-1:0] cp);
    logic [8:0] res;
    res = 9'd0;
    if ((cp >= 21'd33 && cp <= 21'd126) || (cp >= 21'd161 && cp <= 21'd172) ||
        (cp >= 21'd174 && cp <= 21'd255)) begin
      res = {1'b1, cp[7:0]};
    end else if (cp >= 21'd256 && cp <= 21'd288) begin
      res = {1'b1, cp[7:0]};
    end else if (cp >= 21'd289 && cp <= 21'd322) begin
      res = {1'b1, cp[7:0] - 8'd162};
    end else if (cp == 21'd323) begin
      res = {1'b1, 8'd173};
    end
    return res;
  endfunction

endpackage

/* rtl/btd_front.sv */
module btd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  btd_pkg::in_item_t token_byte,
  input  logic             q_full,
  output logic             full,
  output logic             q_push,
  output btd_pkg::run_t    q_data
);

  logic [2:0][7:0]           held_bytes;
  logic [1:0]                held_count;
  logic [2:0]                expected_length;
  logic [btd_pkg::CP_W-1:0]  code_accumulator;

  logic [btd_pkg::CP_W-1:0]  acc_next;
  logic [2:0]                exp_next;
  logic [2:0]                seen;
  logic                      accept;
  logic                      complete;
  logic [8:0]                mapped;
  logic [7:0]                b;

  assign b      = token_byte.in_byte;
  assign full   = q_full;
  assign accept = push && !q_full;
  assign seen   = {1'b0, held_count} + 3'd1;

  always_comb begin
    if (held_count == 2'd0) begin
      priority if (b[7] == 1'b0) begin
        acc_next = {13'd0, b};
        exp_next = 3'd1;
      end else if (b[7:5] == 3'b110) begin
        acc_next = {16'd0, b[4:0]};
        exp_next = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
        acc_next = {17'd0, b[3:0]};
        exp_next = 3'd3;
      end else begin
        acc_next = {18'd0, b[2:0]};
        exp_next = 3'd4;
      end
    end else begin
      acc_next = {code_accumulator[btd_pkg::CP_W-7:0], b[5:0]};
      exp_next = expected_length;
    end
  end

  assign complete = token_byte.token_end || (seen >= exp_next);
  assign mapped   = btd_pkg::map_code(acc_next);
  assign q_push   = accept && complete;

  always_comb begin
    q_data.tok_end = token_byte.token_end;
    if (mapped[8]) begin
      q_data.bytes    = {24'd0, mapped[7:0]};
      q_data.last_idx = 2'd0;
    end else begin
      q_data.last_idx = held_count;
      for (int k = 0; k < 3; k++) begin
        if (k == int'(held_count)) begin
          q_data.bytes[k] = b;
        end else begin
          q_data.bytes[k] = held_bytes[k];
        end
      end
      q_data.bytes[3] = b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes       <= '0;
      held_count       <= 2'd0;
      expected_length  <= 3'd0;
      code_accumulator <= '0;
    end else if (accept) begin
      if (complete) begin
        held_count       <= 2'd0;
        expected_length  <= 3'd0;
        code_accumulator <= '0;
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (i == int'(held_count)) begin
            held_bytes[i] <= b;
          end
        end
        held_count       <= held_count + 2'd1;
        expected_length  <= exp_next;
        code_accumulator <= acc_next;
      end
    end
  end

endmodule

/* rtl/btd_queue.sv */
module btd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  btd_pkg::run_t wdata,
  output logic          full,
  input  logic          pop,
  output btd_pkg::run_t rdata,
  output logic          empty
);

  localparam int unsigned AW = btd_pkg::RUN_Q_AW;

  btd_pkg::run_t slots [btd_pkg::RUN_Q_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == (AW+1)'(btd_pkg::RUN_Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(btd_pkg::RUN_Q_DEPTH))
    else $error("run queue count exceeds its depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + (AW+1)'(1)))
    else $error("run queue count did not follow a lone push");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst)
    (rd_ptr + count[AW-1:0]) == wr_ptr)
    else $error("run queue pointers disagree with its count");

endmodule

/* rtl/btd_back.sv */
module btd_back (
  input  logic              clk,
  input  logic              rst,
  input  btd_pkg::run_t     q_data,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output btd_pkg::out_item_t result
);

  btd_pkg::run_t cur;
  logic          cur_valid;
  logic [1:0]    idx;
  logic          at_last;
  logic          load;

  assign at_last = (idx == cur.last_idx);
  assign empty   = !cur_valid;
  assign load    = !cur_valid || (pop && at_last);
  assign q_pop   = load && !q_empty;

  assign result.out_byte    = cur.bytes[idx];
  assign result.last_of_run = at_last;
  assign result.token_done  = at_last && cur.tok_end;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      cur_valid <= !q_empty;
      idx       <= 2'd0;
    end else if (pop) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

/* rtl/byte_level_token_decoder.sv */
// Byte-level token decoder: undoes the byte-to-unicode mapping of a byte-level
// BPE vocabulary, fed with the UTF-8 text of tokens one byte per transfer.
//
// Input side (queue-like): token_byte carries a byte and a token_end flag. A
// transfer happens at a clock edge where push is high and full is low. One
// byte can be taken every cycle; full rises only when the internal run queue
// of four finished code points is full.
//
// Result side (queue-like): while empty is low, result holds the oldest
// decoded byte; a transfer happens at an edge where pop is high. A mapped code
// point gives one result, an unmapped one gives back its one to four raw bytes,
// one per cycle while pop is high. last_of_run marks the final result of a run,
// token_done marks it when the token ended there.
//
// The first result of a code point is registered in the run queue and then in
// the back end's run register before it shows on the port. When pop stays
// low, finished runs pile up in the queue and then full holds the input off.
// A synchronous reset drops any half-gathered code point and results.
module byte_level_token_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  btd_pkg::in_item_t  token_byte,
  output logic               empty,
  input  logic               pop,
  output btd_pkg::out_item_t result
);

  btd_pkg::run_t wr_run;
  btd_pkg::run_t rd_run;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;

  // The front end gathers a code point and maps it, producing one run per
  // completed code point.
  btd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .token_byte (token_byte),
    .q_full     (q_full),
    .full       (full),
    .q_push     (q_push),
    .q_data     (wr_run)
  );

  // The run queue lets the front keep taking bytes while a long run drains.
  btd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (wr_run),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (rd_run),
    .empty (q_empty)
  );

  // The back end walks each run byte by byte toward the result port.
  btd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (rd_run),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule
